@@ design/ndgs_pkg.sv @@
// Shared types and codes of the N-dimensional gather/scatter block.
`timescale 1ns / 1ps
package ndgs_pkg;

	// Request modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_GS    = 2'd2;
	localparam logic [1:0] MODE_NOP   = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_COORD = 2'd1;
	localparam logic [1:0] ST_TABLE = 2'd2;
	localparam logic [1:0] ST_LANE  = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_DIRECTION   = 3'd0;
	localparam logic [2:0] REG_ACCUMULATE  = 3'd1;
	localparam logic [2:0] REG_SLICE_LEN   = 3'd2;
	localparam logic [2:0] REG_COORD_CNT   = 3'd3;
	localparam logic [2:0] REG_DIM0        = 3'd4;
	localparam logic [2:0] REG_DIM1        = 3'd5;
	localparam logic [2:0] REG_DIM2        = 3'd6;
	localparam logic [2:0] REG_DIM3        = 3'd7;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int NUM_COORDS  = 4;

	typedef struct packed {
		logic        [1:0]  mode;
		logic        [7:0]  batch;
		logic signed [15:0] coord0;
		logic signed [15:0] coord1;
		logic signed [15:0] coord2;
		logic signed [15:0] coord3;
		logic        [7:0]  lane;
		logic signed [31:0] value;
	} ndgs_req_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic        [1:0]  status;
	} ndgs_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic       load_item;
		logic       mac_init;
		logic       mac_step;
		logic       mac_slice;
		logic [1:0] mac_idx;
		logic       rd_en;
		logic       exec;
		logic       res_load;
		logic       res_mem;
		logic [1:0] res_status;
		logic       out_load;
	} ndgs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] mode;
		logic       coord_err;
		logic       lane_err;
		logic       acc_big;
		logic [2:0] depth;
	} ndgs_stat_t;

endpackage

@@ design/ndgs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ndgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/ndgs_dp.sv @@
// Datapath: configuration registers, index checks, offset multiply-add and table access.
`timescale 1ns / 1ps
module ndgs_dp
	import ndgs_pkg::*;
#(
	parameter int TABLE_WORDS   = 4096,
	parameter int MAX_DEPTH     = 4,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  ndgs_req_t              req,
	input  ndgs_cmd_t              cmd,
	output ndgs_stat_t             stat,
	output ndgs_rsp_t              rsp
);

	localparam int IW        = $clog2(TABLE_WORDS);
	localparam int AW        = IW + 1;
	localparam int MW        = AW + 15;
	localparam int SW        = AW + 16;
	localparam int DEPTH_CAP = (MAX_DEPTH < NUM_COORDS) ? MAX_DEPTH : NUM_COORDS;

	logic                     direction_q;
	logic                     accumulate_q;
	logic [8:0]               slice_len_q;
	logic [2:0]               coord_cnt_q;
	logic [NUM_COORDS-1:0][14:0] dim_q;

	ndgs_req_t                item_q;
	logic [AW-1:0]            acc_q;
	logic [31:0]              res_data_q;
	logic [1:0]               res_status_q;

	logic [NUM_COORDS-1:0][15:0] crd;
	logic [NUM_COORDS-1:0]    crd_bad;
	logic [2:0]               depth;
	logic [14:0]              mac_op;
	logic [14:0]              mac_add;
	logic [MW-1:0]            mac_prod;
	logic [SW-1:0]            mac_sum;
	logic [AW-1:0]            mac_next;
	logic [AW-1:0]            batch_clamp;

	logic [ELEMENT_WIDTH-1:0] cur;
	logic [ELEMENT_WIDTH-1:0] val_ext;
	logic [ELEMENT_WIDTH-1:0] add_res;
	logic [ELEMENT_WIDTH-1:0] wdata;
	logic                     we;
	logic [31:0]              exec_data;
	logic signed [63:0]       val64;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q   <= 1'b0;
			accumulate_q  <= 1'b0;
			slice_len_q   <= 9'd1;
			coord_cnt_q   <= 3'd1;
			dim_q         <= {NUM_COORDS{15'd1}};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIRECTION:   direction_q   <= cfg_data[0];
				REG_ACCUMULATE:  accumulate_q  <= cfg_data[0];
				REG_SLICE_LEN:   slice_len_q   <= cfg_data[8:0];
				REG_COORD_CNT:   coord_cnt_q   <= cfg_data[2:0];
				REG_DIM0:        dim_q[0]      <= cfg_data[14:0];
				REG_DIM1:        dim_q[1]      <= cfg_data[14:0];
				REG_DIM2:        dim_q[2]      <= cfg_data[14:0];
				REG_DIM3:        dim_q[3]      <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Capture the accepted request
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= req;
		end
	end

	// Saturate the used depth
	assign depth = (coord_cnt_q > 3'(DEPTH_CAP)) ? 3'(DEPTH_CAP) : coord_cnt_q;

	// Check every used coordinate against its extent
	assign crd = {item_q.coord3, item_q.coord2, item_q.coord1, item_q.coord0};
	always_comb begin
		for (int h = 0; h < NUM_COORDS; h++) begin
			crd_bad[h] = (3'(h) < depth) && (crd[h][15] || (crd[h][14:0] >= dim_q[h]));
		end
	end

	assign stat.mode      = item_q.mode;
	assign stat.coord_err = |crd_bad;
	assign stat.lane_err  = {1'b0, item_q.lane} >= slice_len_q;
	assign stat.acc_big   = acc_q >= AW'(TABLE_WORDS);
	assign stat.depth     = depth;

	// Horner step: acc = min(acc * extent + coordinate, TABLE_WORDS), or slice length and lane on the slice step
	assign mac_op   = cmd.mac_slice ? 15'(slice_len_q) : dim_q[cmd.mac_idx];
	assign mac_add  = cmd.mac_slice ? 15'(item_q.lane) : crd[cmd.mac_idx][14:0];
	assign mac_prod = MW'(acc_q) * MW'(mac_op);
	assign mac_sum  = SW'(mac_prod) + SW'(mac_add);
	assign mac_next = (mac_sum >= SW'(TABLE_WORDS)) ? AW'(TABLE_WORDS) : mac_sum[AW-1:0];

	assign batch_clamp = ((AW + 8)'(item_q.batch) >= (AW + 8)'(TABLE_WORDS)) ?
		AW'(TABLE_WORDS) : AW'(item_q.batch);

	// Advance the address accumulator
	always_ff @(posedge clk) begin
		if (cmd.mac_init) begin
			acc_q <= batch_clamp;
		end else if (cmd.mac_step) begin
			acc_q <= mac_next;
		end
	end

	// Element arithmetic, wrapping at the element width
	assign val64   = 64'(item_q.value);
	assign val_ext = ELEMENT_WIDTH'(val64);
	assign add_res = cur + val_ext;
	assign wdata   = (item_q.mode == MODE_GS && accumulate_q) ? add_res : val_ext;
	assign we      = cmd.exec &&
		(item_q.mode == MODE_WRITE || (item_q.mode == MODE_GS && direction_q));

	always_comb begin
		exec_data = '0;
		case (item_q.mode)
			MODE_READ: exec_data = 32'(cur);
			MODE_GS: begin
				if (!direction_q) begin
					exec_data = accumulate_q ? 32'(add_res) : 32'(cur);
				end
			end
			default: exec_data = '0;
		endcase
	end

	ndgs_ram #(
		.WIDTH(ELEMENT_WIDTH),
		.DEPTH(TABLE_WORDS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(acc_q[IW-1:0]),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(acc_q[IW-1:0]),
		.rdata(cur)
	);

	// Hold the finished result
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_data_q   <= cmd.res_mem ? exec_data : 32'd0;
			res_status_q <= cmd.res_status;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp.data   <= res_data_q;
			rsp.status <= res_status_q;
		end
	end

endmodule

@@ design/ndgs_ctrl.sv @@
// Controller: sequences check, offset build, table access and result handoff.
`timescale 1ns / 1ps
module ndgs_ctrl
	import ndgs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  ndgs_stat_t stat,
	output ndgs_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_MAC   = 3'd2;
	localparam logic [2:0] S_BOUND = 3'd3;
	localparam logic [2:0] S_EXEC  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] step_q;
	logic [2:0] step_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.mode == MODE_NOP) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_DONE;
				end else if (stat.coord_err) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_COORD;
					state_d        = S_DONE;
				end else if (stat.lane_err) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_LANE;
					state_d        = S_DONE;
				end else begin
					cmd.mac_init = 1'b1;
					step_d       = 3'd0;
					state_d      = S_MAC;
				end
			end
			S_MAC: begin
				cmd.mac_step = 1'b1;
				cmd.mac_idx  = step_q[1:0];
				if (step_q < stat.depth) begin
					step_d = step_q + 3'd1;
				end else begin
					cmd.mac_slice = 1'b1;
					state_d       = S_BOUND;
				end
			end
			S_BOUND: begin
				if (stat.acc_big) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_TABLE;
					state_d        = S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec       = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_mem    = 1'b1;
				cmd.res_status = ST_OK;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/nd_index_gather_scatter_core.sv @@
// Top level of the N-dimensional index gather/scatter block.
// Usage:
//   cfg channel writes the registers (direction, accumulate, slice length,
//   coordinate count, dim0..dim3) by index; it is always ready and must only
//   be used while the block is idle.
//   in channel takes one request: mode, batch, coordinates, lane, value.
//   out channel returns one response per request: data and status.
// Sequence: an accepted request passes the coordinate and lane check, the
//   chained multiply-add (one dimension per cycle, then the slice), the
//   table bound check, and the table read before the write-back, and is
//   then loaded into the output register. A beyond-table error skips the
//   table access; a coordinate or lane error or a no-op goes straight from
//   the check to the output register. One request is in work at a time;
//   the next is accepted once the previous one has moved to the output
//   register, even if it still waits.
// Reset: configuration and controller registers return to their defaults;
//   datapath registers and table contents are undefined until written.
// Stall: while out_ready is low the response holds; a finished request
//   waits in the controller until the output register frees.
`timescale 1ns / 1ps
module nd_index_gather_scatter_core
	import ndgs_pkg::*;
#(
	parameter int TABLE_WORDS   = 4096,
	parameter int MAX_DEPTH     = 4,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ndgs_req_t              in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ndgs_rsp_t              out_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	ndgs_cmd_t  cmd;
	ndgs_stat_t stat;

	assign cfg_ready = 1'b1;

	ndgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ndgs_dp #(
		.TABLE_WORDS  (TABLE_WORDS),
		.MAX_DEPTH    (MAX_DEPTH),
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (in_item),
		.cmd      (cmd),
		.stat     (stat),
		.rsp      (out_item)
	);

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the N-dimensional index gather/scatter block.
`timescale 1ns / 1ps
module tb;
	import ndgs_pkg::*;

	localparam int TABLE_WORDS = 4096;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam longint unsigned ADDR_CEIL = 64'd1 << 40;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  data;
	} reg_write_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	ndgs_req_t              in_item   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	ndgs_rsp_t              out_item;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_DIRECTION;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Register image as the block should hold it
	logic        sh_dir   = 1'b0;
	logic        sh_acc   = 1'b0;
	logic [8:0]  sh_slice = 9'd1;
	logic [2:0]  sh_depth = 3'd1;
	logic [14:0] sh_dim [4] = '{default: 15'd1};

	// Table contents as the block should hold them, and words the stimulus has written
	logic [31:0] table_image [TABLE_WORDS];
	bit          gen_written [TABLE_WORDS];

	ndgs_req_t  req_backlog [$];
	ndgs_req_t  landed_req [$];
	ndgs_rsp_t  rsp_due [$];
	reg_write_t reg_backlog [$];
	reg_write_t reg_next;
	ndgs_rsp_t  want_rsp;

	bit steady_in  = 1'b0;
	bit steady_out = 1'b0;
	int send_gap   = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int fault_count  = 0;
	int sent_count   = 0;
	int checked_count = 0;
	int shape_count  = 1;
	int status_seen [4] = '{default: 0};

	nd_index_gather_scatter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #1 clk = ~clk;

	function automatic longint unsigned clamp_addr(longint unsigned v);
		return (v > ADDR_CEIL) ? ADDR_CEIL : v;
	endfunction

	// Check the coordinates and lane, then build the row-major element address
	function automatic void resolve_element(input ndgs_req_t r, output logic [1:0] st,
			output longint unsigned addr);
		logic signed [15:0] crd [4];
		longint unsigned off, span, c;
		int used;
		crd = '{r.coord0, r.coord1, r.coord2, r.coord3};
		used = (sh_depth > 3'd4) ? 4 : int'(sh_depth);
		off = 0;
		span = 1;
		addr = 0;
		st = ST_OK;
		for (int h = 0; h < used; h++) begin
			c = 64'(crd[h][14:0]);
			if (crd[h][15] || c >= sh_dim[h]) begin
				st = ST_COORD;
				return;
			end
			off = clamp_addr(off * sh_dim[h] + c);
			span = clamp_addr(span * sh_dim[h]);
		end
		if (r.lane >= sh_slice) begin
			st = ST_LANE;
			return;
		end
		addr = clamp_addr(r.batch * span);
		addr = clamp_addr(addr + off);
		addr = clamp_addr(addr * sh_slice);
		addr = clamp_addr(addr + r.lane);
		if (addr >= TABLE_WORDS)
			st = ST_TABLE;
	endfunction

	// Work out the response of one request and update the table image
	function automatic ndgs_rsp_t compute_response(ndgs_req_t r);
		ndgs_rsp_t rsp;
		logic [1:0] st;
		longint unsigned a;
		logic [31:0] cur;
		rsp = '0;
		if (r.mode == MODE_NOP)
			return rsp;
		resolve_element(r, st, a);
		rsp.status = st;
		if (st != ST_OK)
			return rsp;
		cur = table_image[a[11:0]];
		case (r.mode)
			MODE_WRITE: begin
				table_image[a[11:0]] = r.value;
			end
			MODE_READ: begin
				rsp.data = cur;
			end
			default: begin
				if (!sh_dir)
					rsp.data = sh_acc ? cur + r.value : cur;
				else
					table_image[a[11:0]] = sh_acc ? cur + r.value : r.value;
			end
		endcase
		return rsp;
	endfunction

	// Queue a request; turn a read of a never-written word into a write of it
	function automatic void queue_request(ndgs_req_t r);
		logic [1:0] st;
		longint unsigned a;
		bit reads;
		if (r.mode != MODE_NOP) begin
			resolve_element(r, st, a);
			if (st == ST_OK) begin
				reads = (r.mode == MODE_READ) || (r.mode == MODE_GS && (!sh_dir || sh_acc));
				if (reads && !gen_written[a[11:0]])
					r.mode = MODE_WRITE;
				if (r.mode == MODE_WRITE || (r.mode == MODE_GS && sh_dir))
					gen_written[a[11:0]] = 1'b1;
				landed_req.push_back(r);
				if (landed_req.size() > 64)
					void'(landed_req.pop_front());
			end
		end
		req_backlog.push_back(r);
	endfunction

	function automatic ndgs_req_t req_of(logic [1:0] mode, logic [7:0] batch,
			logic signed [15:0] c0, logic signed [15:0] c1, logic signed [15:0] c2,
			logic signed [15:0] c3, logic [7:0] lane, logic [31:0] value);
		ndgs_req_t r;
		r.mode = mode;
		r.batch = batch;
		r.coord0 = c0;
		r.coord1 = c1;
		r.coord2 = c2;
		r.coord3 = c3;
		r.lane = lane;
		r.value = value;
		return r;
	endfunction

	// Mostly well-formed requests within the current shape, some revisits, some noise
	function automatic ndgs_req_t random_request();
		ndgs_req_t r;
		logic [127:0] raw;
		logic [1:0] op;
		logic signed [15:0] crd [4];
		longint unsigned span, block;
		int used, k, maxb;
		raw = {$urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(ndgs_req_t)-1:0];
		k = $urandom_range(0, 99);
		op = (k < 30) ? MODE_WRITE : (k < 55) ? MODE_READ : (k < 95) ? MODE_GS : MODE_NOP;
		k = $urandom_range(0, 99);
		if (k < 10)
			return r;
		if (k < 50 && landed_req.size() > 0) begin
			r = landed_req[$urandom_range(0, landed_req.size() - 1)];
			r.mode = op;
			r.value = raw[31:0];
			return r;
		end
		r.mode = op;
		used = (sh_depth > 3'd4) ? 4 : int'(sh_depth);
		span = 1;
		for (int h = 0; h < 4; h++) begin
			if (h < used && sh_dim[h] != 0) begin
				crd[h] = 16'($urandom_range(0, sh_dim[h] - 1));
				span = clamp_addr(span * sh_dim[h]);
			end else begin
				crd[h] = raw[16*h +: 16];
			end
		end
		// break one coordinate now and then
		if (used > 0 && $urandom_range(0, 19) == 0) begin
			k = $urandom_range(0, used - 1);
			crd[k] = $urandom_range(0, 1) ? {1'b0, sh_dim[k]} : {1'b1, raw[46:32]};
		end
		r.coord0 = crd[0];
		r.coord1 = crd[1];
		r.coord2 = crd[2];
		r.coord3 = crd[3];
		if (sh_slice != 0 && $urandom_range(0, 19) != 0)
			r.lane = 8'($urandom_range(0, ((sh_slice > 256) ? 256 : sh_slice) - 1));
		block = span * sh_slice;
		maxb = (block == 0 || block > TABLE_WORDS) ? 0 : int'(TABLE_WORDS / block);
		if ($urandom_range(0, 19) != 0)
			r.batch = 8'($urandom_range(0, (maxb > 255) ? 255 : maxb));
		return r;
	endfunction

	function automatic int idle_len();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	task automatic fill_random(int count);
		for (int i = 0; i < count; i++)
			queue_request(random_request());
	endtask

	// Wait until every request is sent and every response has come back
	task automatic drain();
		while (req_backlog.size() != 0 || in_valid || rsp_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all eight registers while idle; junk goes above each field now and then
	task automatic set_shape(input int v [8]);
		int w [8];
		logic [CFG_INDEX_W-1:0] regs [8];
		reg_write_t rw;
		w = '{1, 1, 9, 3, 15, 15, 15, 15};
		regs = '{REG_DIRECTION, REG_ACCUMULATE, REG_SLICE_LEN, REG_COORD_CNT,
			REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3};
		drain();
		for (int i = 0; i < 8; i++) begin
			rw.idx = regs[i];
			rw.data = CFG_DATA_W'(v[i]);
			if ($urandom_range(0, 1))
				rw.data = rw.data | (CFG_DATA_W'($urandom) & ~((CFG_DATA_W'(1) << w[i]) - 1));
			reg_backlog.push_back(rw);
		end
		while (reg_backlog.size() != 0 || cfg_valid)
			@(negedge clk);
		landed_req.delete();
		shape_count++;
		steady_in = ($urandom_range(0, 3) == 0);
		steady_out = ($urandom_range(0, 3) == 0);
	endtask

	// Register port: apply accepted writes to the image, then present the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= REG_DIRECTION;
			cfg_data <= '0;
			sh_dir = 1'b0;
			sh_acc = 1'b0;
			sh_slice = 9'd1;
			sh_depth = 3'd1;
			sh_dim = '{default: 15'd1};
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DIRECTION:   sh_dir = cfg_data[0];
					REG_ACCUMULATE:  sh_acc = cfg_data[0];
					REG_SLICE_LEN:   sh_slice = cfg_data[8:0];
					REG_COORD_CNT:   sh_depth = cfg_data[2:0];
					REG_DIM0:        sh_dim[0] = cfg_data[14:0];
					REG_DIM1:        sh_dim[1] = cfg_data[14:0];
					REG_DIM2:        sh_dim[2] = cfg_data[14:0];
					REG_DIM3:        sh_dim[3] = cfg_data[14:0];
					default:         ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_backlog.size() != 0) begin
					reg_next = reg_backlog.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= reg_next.idx;
					cfg_data <= reg_next.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Request driver: predict on acceptance, hold until accepted, insert random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				rsp_due.push_back(compute_response(in_item));
				sent_count++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					in_item <= req_backlog.pop_front();
					in_valid <= 1'b1;
					send_gap <= (steady_in || $urandom_range(0, 3) != 0) ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compare against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (rsp_due.size() == 0) begin
					$error("unexpected response: data %0d status %0d",
						out_item.data, out_item.status);
					fault_count++;
				end else begin
					want_rsp = rsp_due.pop_front();
					checked_count++;
					status_seen[want_rsp.status]++;
					if (out_item.data !== want_rsp.data) begin
						$error("data mismatch: expected %0d actual %0d",
							want_rsp.data, out_item.data);
						fault_count++;
					end
					if (out_item.status !== want_rsp.status) begin
						$error("status mismatch: expected %0d actual %0d",
							want_rsp.status, out_item.status);
						fault_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!steady_out && $urandom_range(0, 3) == 0)
					stall_left <= idle_len();
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int rv [8];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset shape: depth one, unit extents, one-element slices, plain gather
		queue_request(req_of(MODE_WRITE, 8'd200, 16'sd0, -16'sd32768, 16'sd32767, -16'sd1,
			8'd0, 32'h7fff_ffff));
		queue_request(req_of(MODE_READ, 8'd200, 16'sd0, 16'sd5, 16'sd5, 16'sd5, 8'd0, 32'd0));
		queue_request(req_of(MODE_GS, 8'd200, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0,
			32'h1234_5678));
		queue_request(req_of(MODE_READ, 8'd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 8'd0, 32'd0));
		// bad coordinate outranks bad lane
		queue_request(req_of(MODE_READ, 8'd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 8'd255,
			32'd0));
		queue_request(req_of(MODE_READ, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd1, 32'd0));
		queue_request(req_of(MODE_NOP, 8'd255, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 8'd255,
			32'hffff_ffff));
		fill_random(10);

		// depth zero over the whole table, scatter overwrite
		rv = '{1, 0, 256, 0, 32767, 32767, 32767, 32767};
		set_shape(rv);
		queue_request(req_of(MODE_WRITE, 8'd15, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0,
			8'd255, 32'h8000_0000));
		queue_request(req_of(MODE_READ, 8'd15, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd255, 32'd0));
		queue_request(req_of(MODE_GS, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 32'd1));
		queue_request(req_of(MODE_READ, 8'd16, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 32'd0));
		queue_request(req_of(MODE_READ, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 32'd0));
		fill_random(10);

		// full depth, gather with accumulate and wrap
		rv = '{0, 1, 4, 4, 4, 4, 4, 4};
		set_shape(rv);
		queue_request(req_of(MODE_WRITE, 8'd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 8'd3,
			32'h7fff_ffff));
		queue_request(req_of(MODE_GS, 8'd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 8'd3, 32'd1));
		queue_request(req_of(MODE_READ, 8'd0, 16'sd3, 16'sd3, 16'sd3, 16'sd4, 8'd0, 32'd0));
		queue_request(req_of(MODE_READ, 8'd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 32'd0));
		// bad lane outranks the table bound
		queue_request(req_of(MODE_READ, 8'd255, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd4, 32'd0));
		fill_random(10);

		// oversized depth saturates to four, scatter with accumulate
		rv = '{1, 1, 2, 7, 3, 5, 7, 2};
		set_shape(rv);
		queue_request(req_of(MODE_WRITE, 8'd1, 16'sd2, 16'sd4, 16'sd6, 16'sd1, 8'd1,
			32'hffff_ffff));
		queue_request(req_of(MODE_GS, 8'd1, 16'sd2, 16'sd4, 16'sd6, 16'sd1, 8'd1, 32'd1));
		queue_request(req_of(MODE_READ, 8'd1, 16'sd2, 16'sd4, 16'sd6, 16'sd1, 8'd1, 32'd0));
		fill_random(10);

		// zero slice length rejects every lane
		rv = '{0, 0, 0, 1, 8, 1, 1, 1};
		set_shape(rv);
		queue_request(req_of(MODE_READ, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 32'd0));
		queue_request(req_of(MODE_READ, 8'd0, 16'sd8, 16'sd0, 16'sd0, 16'sd0, 8'd0, 32'd0));
		fill_random(10);

		// zero extent rejects every coordinate
		rv = '{0, 0, 16, 3, 4, 0, 4, 4};
		set_shape(rv);
		queue_request(req_of(MODE_WRITE, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 32'd9));
		fill_random(10);

		// huge extents: the address saturates and lands beyond the table
		rv = '{1, 0, 511, 4, 32767, 32767, 32767, 32767};
		set_shape(rv);
		queue_request(req_of(MODE_WRITE, 8'd255, 16'sd32766, 16'sd32766, 16'sd32766,
			16'sd32766, 8'd255, 32'd7));
		queue_request(req_of(MODE_WRITE, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 32'd7));
		fill_random(10);

		// random shapes, mostly small
		for (int p = 0; p < 9; p++) begin
			rv[0] = $urandom_range(0, 1);
			rv[1] = $urandom_range(0, 1);
			case ($urandom_range(0, 19))
				0:       rv[2] = 0;
				1:       rv[2] = 256;
				2:       rv[2] = 511;
				default: rv[2] = $urandom_range(1, 16);
			endcase
			rv[3] = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
			for (int d = 4; d < 8; d++) begin
				case ($urandom_range(0, 39))
					0:       rv[d] = 32767;
					1:       rv[d] = 0;
					default: rv[d] = $urandom_range(1, 6);
				endcase
			end
			set_shape(rv);
			fill_random(95);
		end

		drain();
		$display("summary: %0d requests under %0d register settings, %0d responses checked",
			sent_count, shape_count, checked_count);
		$display("summary: status ok %0d, coordinate %0d, beyond table %0d, lane %0d",
			status_seen[ST_OK], status_seen[ST_COORD], status_seen[ST_TABLE],
			status_seen[ST_LANE]);
		if (fault_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/ndgs_pkg.sv
design/ndgs_ram.sv
design/ndgs_dp.sv
design/ndgs_ctrl.sv
design/nd_index_gather_scatter_core.sv
verif/tb.sv
